[hw/rtl/sha1md_pkg.sv]
// Shared types, constants and helper functions of the SHA-1 digest engine.
`default_nettype none

package sha1md_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned NumChain   = 5;
   localparam int unsigned NumSched   = 16;

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenPos    = 6'd56;
   localparam logic [5:0] LastPos   = 6'd63;
   localparam logic [6:0] LastRound = 7'd79;
   localparam logic [2:0] LastWord  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       finish;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] word;
      unique case (idx)
         3'd0:    word = 32'h67452301;
         3'd1:    word = 32'hEFCDAB89;
         3'd2:    word = 32'h98BADCFE;
         3'd3:    word = 32'h10325476;
         3'd4:    word = 32'hC3D2E1F0;
         default: word = 32'h00000000;
      endcase
      return word;
   endfunction

   function automatic logic [31:0] round_const(input logic [6:0] t);
      logic [31:0] k;
      priority if (t < 7'd20) begin
         k = 32'h5A827999;
      end else if (t < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (t < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   function automatic logic [31:0] round_func(input logic [6:0] t, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      priority if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t < 7'd40) begin
         f = b ^ c ^ d;
      end else if (t < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/sha1md_if.sv]
// Request and response channel interfaces of the SHA-1 digest engine.
`default_nettype none

interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       finish;

   modport source(output valid, output data_byte, output byte_valid, output finish,
                  input ready);
   modport sink(input valid, input data_byte, input byte_valid, input finish,
                output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source(output valid, output digest_word, output word_index, output last_word,
                  input ready);
   modport sink(input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/sha1_message_digest_top.sv]
// Throughput: requests enter a QUEUE_DEPTH-deep queue at one per cycle while it has room; the core
// absorbs one byte per cycle, and each full 64-byte block stops absorption for 80 rounds and a fold.
// After a finish: padding, one or two compressions, then five digest words, one per cycle as the
// response side takes them.
// Reset is synchronous and active high; it restores the initial chaining values, clears the
// bit count and empties the queue. The block buffer is not cleared.
`default_nettype none

module sha1_message_digest_top
   import sha1md_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   sha1md_req_if.sink   req_chan,
   sha1md_rsp_if.source rsp_chan
);

   queue_head_type q_head;
   logic           q_pop;

   sha1md_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (q_head),
      .pop      (q_pop)
   );

   sha1md_core u_core (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[hw/rtl/sha1md_front.sv]
// Request front end: drops empty requests and queues the rest for the hash core.
`default_nettype none

module sha1md_front
   import sha1md_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic           clock,
   input  logic           reset,
   sha1md_req_if.sink     req_chan,
   output queue_head_type head,
   input  logic           pop
);

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                take, push, do_pop;

   assign req_chan.ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign take   = req_chan.valid && req_chan.ready;
   // A request with neither a byte nor a finish changes nothing, so it is not queued.
   assign push   = take && (req_chan.byte_valid || req_chan.finish);
   assign do_pop = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data_byte:  req_chan.data_byte,
                                 byte_valid: req_chan.byte_valid,
                                 finish:     req_chan.finish};
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sha1md_core.sv]
// Hash core: byte packing, padding sequencer, 80-round compression and digest output.
`default_nettype none

module sha1md_core
   import sha1md_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   sha1md_rsp_if.source   rsp_chan
);

   typedef enum logic [4:0] {
      ST_ABSORB = 5'b00001,
      ST_PAD    = 5'b00010,
      ST_ROUND  = 5'b00100,
      ST_FOLD   = 5'b01000,
      ST_OUTPUT = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [31:0] chain_ff [NumChain];
   logic [31:0] chain_in [NumChain];
   logic [31:0] win_ff [NumSched];
   logic [23:0] acc_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  round_ff, round_in;
   logic        fin_ff, fin_in;
   logic        mark_ff, mark_in;
   logic        len_ff, len_in;
   logic [2:0]  idx_ff, idx_in;

   logic        put_en, len_sel, word_done, block_done;
   logic [7:0]  put_byte;
   logic [31:0] new_word, sched_word, temp_word;

   assign pop = (state_ff == ST_ABSORB) && head.valid;

   // In the padding phase the length bytes start once the marker is placed and
   // the write position has reached the length field.
   assign len_sel = mark_ff && (len_ff || (pos_ff == LenPos));

   always_comb begin
      put_en   = 1'b0;
      put_byte = head.item.data_byte;
      unique case (state_ff)
         ST_ABSORB: begin
            put_en   = head.valid && head.item.byte_valid;
            put_byte = head.item.data_byte;
         end
         ST_PAD: begin
            put_en = 1'b1;
            if (!mark_ff) begin
               put_byte = PadByte;
            end else if (len_sel) begin
               put_byte = bit_count_ff[63:56];
            end else begin
               put_byte = 8'h00;
            end
         end
         ST_ROUND, ST_FOLD, ST_OUTPUT: begin
            put_en = 1'b0;
         end
         default: begin
            put_en = 1'b0;
         end
      endcase
   end

   assign new_word   = {acc_ff, put_byte};
   assign word_done  = put_en && (pos_ff[1:0] == 2'b11);
   assign block_done = put_en && (pos_ff == LastPos);

   assign sched_word = {win_ff[13][30:0] ^ win_ff[8][30:0] ^ win_ff[2][30:0] ^ win_ff[0][30:0],
                        win_ff[13][31] ^ win_ff[8][31] ^ win_ff[2][31] ^ win_ff[0][31]};
   assign temp_word  = {a_ff[26:0], a_ff[31:27]} + round_func(round_ff, b_ff, c_ff, d_ff)
                       + e_ff + round_const(round_ff) + win_ff[0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      bit_count_in = bit_count_ff;
      round_in     = round_ff;
      fin_in       = fin_ff;
      mark_in      = mark_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      for (int i = 0; i < NumChain; i++) begin
         chain_in[i] = chain_ff[i];
      end

      if (put_en) begin
         pos_in = pos_ff + 6'd1;
      end

      unique case (state_ff)
         ST_ABSORB: begin
            if (head.valid) begin
               if (head.item.byte_valid) begin
                  bit_count_in = bit_count_ff + 64'd8;
               end
               if (block_done) begin
                  state_in = ST_ROUND;
                  fin_in   = head.item.finish;
               end else if (head.item.finish) begin
                  state_in = ST_PAD;
                  fin_in   = 1'b1;
               end
            end
         end
         ST_PAD: begin
            mark_in = 1'b1;
            if (len_sel) begin
               len_in       = 1'b1;
               bit_count_in = {bit_count_ff[55:0], 8'h00};
            end
            if (block_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == LastRound) begin
               round_in = '0;
               state_in = ST_FOLD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            priority if (len_ff) begin
               state_in = ST_OUTPUT;
               idx_in   = '0;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_ABSORB;
            end
         end
         ST_OUTPUT: begin
            if (rsp_chan.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LastWord) begin
                  state_in     = ST_ABSORB;
                  idx_in       = '0;
                  bit_count_in = '0;
                  pos_in       = '0;
                  fin_in       = 1'b0;
                  mark_in      = 1'b0;
                  len_in       = 1'b0;
                  for (int i = 0; i < NumChain; i++) begin
                     chain_in[i] = init_word(3'(i));
                  end
               end
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ABSORB;
         pos_ff       <= '0;
         bit_count_ff <= '0;
         round_ff     <= '0;
         fin_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         len_ff       <= 1'b0;
         idx_ff       <= '0;
         for (int i = 0; i < NumChain; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bit_count_ff <= bit_count_in;
         round_ff     <= round_in;
         fin_ff       <= fin_in;
         mark_ff      <= mark_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         for (int i = 0; i < NumChain; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   // The schedule window holds w[t..t+15]; bytes fill it from the top and the
   // rounds keep extending it with the next schedule word.
   always_ff @(posedge clock) begin
      if (put_en) begin
         acc_ff <= new_word[23:0];
      end
      if (word_done || (state_ff == ST_ROUND)) begin
         for (int i = 0; i < NumSched - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[NumSched - 1] <= word_done ? new_word : sched_word;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff != ST_ROUND) && (state_in == ST_ROUND)) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (state_ff == ST_ROUND) begin
         a_ff <= temp_word;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   assign rsp_chan.valid       = (state_ff == ST_OUTPUT);
   assign rsp_chan.digest_word = chain_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = (idx_ff == LastWord);

endmodule

`default_nettype wire

[sim/tb_sha1_message_digest_top.sv]
// Self-checking testbench for the byte-stream SHA-1 digest engine.
`default_nettype none

module tb_sha1_message_digest_top;
   import sha1md_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [159:0] Sha1Iv =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
   localparam int unsigned TargetItems = 310;
   localparam int unsigned DrainCycles = 300;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1md_req_if req_chan();
   sha1md_rsp_if rsp_chan();

   sha1_message_digest_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   logic [31:0] hash_state [5];
   logic [31:0] msg_block [16];
   logic [63:0] msg_bits;

   item_type       pending_items [$];
   digest_out_type expected_words [$];
   item_type       drive_item;
   digest_out_type got_word;
   digest_out_type want_word;
   int unsigned    counted_items = 0;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;
   logic           req_taken = 1'b0;
   logic           calm_window;

   // A stretch of the run where neither side idles.
   assign calm_window = (cycle_count >= 1500) && (cycle_count < 3500);

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic reset_hash();
      for (int i = 0; i < 5; i++) begin
         hash_state[i] = Sha1Iv[159 - 32 * i -: 32];
      end
      msg_bits = 64'd0;
   endtask

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, tmp;
      for (int i = 0; i < 16; i++) begin
         w[i] = msg_block[i];
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
            w[t % 16] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         tmp = rotl(a, 5) + f + e + k + wt;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endtask

   // The first byte of a word replaces the whole word; later bytes are ORed in.
   task automatic place_byte(input logic [5:0] pos, input logic [7:0] v);
      int          sh;
      logic [31:0] word;
      sh = 8 * (3 - int'(pos[1:0]));
      word = 32'(v) << sh;
      if (pos[1:0] == 2'd0) begin
         msg_block[pos[5:2]] = word;
      end else begin
         msg_block[pos[5:2]] |= word;
      end
      if (pos == LastPos) begin
         compress_block();
      end
   endtask

   task automatic absorb_request(input item_type it);
      logic [63:0] len;
      logic [5:0]  pos;
      if (it.byte_valid) begin
         place_byte(msg_bits[8:3], it.data_byte);
         msg_bits += 64'd8;
      end
      if (it.finish) begin
         len = msg_bits;
         pos = msg_bits[8:3];
         place_byte(pos, PadByte);
         pos = pos + 6'd1;
         while (pos != LenPos) begin
            place_byte(pos, 8'h00);
            pos = pos + 6'd1;
         end
         for (int i = 0; i < 8; i++) begin
            place_byte(pos, len[63 - 8 * i -: 8]);
            pos = pos + 6'd1;
         end
         for (int i = 0; i < 5; i++) begin
            expected_words.push_back('{digest_word: hash_state[i], word_index: 3'(i),
                                       last_word: (3'(i) == LastWord)});
         end
         reset_hash();
      end
   endtask

   task automatic queue_item(input logic [7:0] b, input logic bv, input logic fin);
      pending_items.push_back('{data_byte: b, byte_valid: bv, finish: fin});
      if (bv || fin) begin
         counted_items++;
      end
   endtask

   // A message of random bytes, with occasional ignored requests mixed in. The finish
   // either rides on the last byte or comes as a request of its own.
   task automatic queue_message(input int unsigned len);
      logic fin_on_last;
      fin_on_last = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            queue_item(8'($urandom), 1'b0, 1'b0);
         end
         queue_item(8'($urandom), 1'b1, fin_on_last && (i == len - 1));
      end
      if (!fin_on_last) begin
         queue_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   // Driver: a request stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm_window || ($urandom_range(0, 99) >= 10);
         if (!req_chan.valid || req_taken) begin
            if (pending_items.size() != 0 && (calm_window || $urandom_range(0, 99) >= 10)) begin
               drive_item = pending_items.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.data_byte  <= drive_item.data_byte;
               req_chan.byte_valid <= drive_item.byte_valid;
               req_chan.finish     <= drive_item.finish;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted digest word.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         reset_hash();
      end else begin
         cycle_count <= cycle_count + 1;
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            absorb_request('{data_byte: req_chan.data_byte, byte_valid: req_chan.byte_valid,
                             finish: req_chan.finish});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_word = '{digest_word: rsp_chan.digest_word, word_index: rsp_chan.word_index,
                         last_word: rsp_chan.last_word};
            if (expected_words.size() == 0) begin
               $error("unexpected digest word %h", got_word.digest_word);
               error_count++;
            end else begin
               want_word = expected_words.pop_front();
               if (got_word.digest_word !== want_word.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want_word.digest_word, got_word.digest_word);
                  error_count++;
               end
               if (got_word.word_index !== want_word.word_index) begin
                  $error("word_index: expected %0d, actual %0d",
                         want_word.word_index, got_word.word_index);
                  error_count++;
               end
               if (got_word.last_word !== want_word.last_word) begin
                  $error("last_word: expected %b, actual %b",
                         want_word.last_word, got_word.last_word);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int unsigned len;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.byte_valid = 1'b0;
      req_chan.finish = 1'b0;
      rsp_chan.ready = 1'b0;

      // Directed part: ignored requests, the empty message, "abc", extreme bytes,
      // and a finish that arrives without a byte after some data.
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      queue_item(8'hFF, 1'b1, 1'b1);
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b1);
      queue_item(8'hA5, 1'b1, 1'b0);
      queue_item(8'h5A, 1'b1, 1'b0);
      queue_item(8'hA5, 1'b0, 1'b1);
      queue_item(8'h00, 1'b0, 1'b1);

      // Padding boundaries: 55 bytes fit one block, 56 need a second, 64 fill one exactly.
      queue_message(55);
      queue_message(56);
      queue_message(64);
      while (counted_items < TargetItems) begin
         if ($urandom_range(0, 99) < 8) begin
            len = $urandom_range(55, 65);
         end else begin
            len = $urandom_range(0, 24);
         end
         queue_message(len);
      end

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_chan.valid) begin
         @(posedge clock);
      end
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
